[rtl/fcspq_pkg.sv]
// Shared types, codes and helpers for the four-class stable priority queue.
package fcspq_pkg;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_CALL = 1'b1;

  localparam logic [1:0] ST_ADDED  = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_CALLED = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  localparam logic [1:0] ROOM_TWO = 2'd2;

  // Broadcast to every cell on an accepted request that changes the queue.
  typedef struct packed {
    logic       do_add;
    logic       do_call;
    logic [1:0] new_cls;
  } fcspq_ctrl_t;

  function automatic logic [1:0] class_room(input logic [1:0] cls);
    class_room = (cls >= ROOM_TWO) ? ROOM_TWO : cls;
  endfunction

endpackage

[rtl/fcspq_cell.sv]
// One slot of the sorted shift chain: holds an identifier and its class.
module fcspq_cell #(
  parameter int ID_W = 16
) (
  input  logic                  clk,
  input  fcspq_pkg::fcspq_ctrl_t ctrl,
  input  logic [ID_W-1:0]       new_id,
  input  logic                  slot_valid,
  input  logic                  left_keep,
  input  logic [ID_W-1:0]       left_id,
  input  logic [1:0]            left_cls,
  input  logic [ID_W-1:0]       right_id,
  input  logic [1:0]            right_cls,
  output logic                  keep,
  output logic [ID_W-1:0]       id,
  output logic [1:0]            cls
);

  logic [ID_W-1:0] id_r, id_nxt;
  logic [1:0]      cls_r, cls_nxt;

  // Entry stays put on an add if it is held and not less urgent than the new one.
  assign keep = slot_valid && (cls_r <= ctrl.new_cls);

  always_comb begin
    id_nxt  = id_r;
    cls_nxt = cls_r;
    if (ctrl.do_add) begin
      if (!keep) begin
        if (left_keep) begin
          id_nxt  = new_id;
          cls_nxt = ctrl.new_cls;
        end else begin
          id_nxt  = left_id;
          cls_nxt = left_cls;
        end
      end
    end else if (ctrl.do_call) begin
      id_nxt  = right_id;
      cls_nxt = right_cls;
    end
  end

  always_ff @(posedge clk) begin
    id_r  <= id_nxt;
    cls_r <= cls_nxt;
  end

  assign id  = id_r;
  assign cls = cls_r;

endmodule

[rtl/four_class_stable_priority_queue.sv]
// Top level: stable four-class priority queue built as a chain of shift cells.
//
//  channel | ports                                      | direction
//  --------+--------------------------------------------+----------
//  in      | in_valid in_ready in_cmd in_patient_id      | request in
//          | in_urgency                                 |
//  out     | out_valid out_ready out_status out_served_id| result out
//          | out_room out_waiting                       |
//
// One request per cycle: every cell compares against the new class in
// parallel and shifts in the same cycle; the result is registered in the
// output register. A request is taken while the output register is
// empty or being drained, so throughput is one per cycle while out_ready is
// high. rst_n (synchronous) empties the queue; cell contents are not reset.
module four_class_stable_priority_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [15:0] in_patient_id,
  input  logic [1:0]  in_urgency,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_served_id,
  output logic [1:0]  out_room,
  output logic [4:0]  out_waiting
);

  localparam int ID_W  = (ID_BITS < 16) ? ID_BITS : 16;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

  logic             in_fire;
  logic             is_full, is_empty;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [15:0]      served_r, served_nxt;
  logic [1:0]       room_r, room_nxt;
  logic [4:0]       waiting_r, waiting_nxt;
  logic [CNT_W+4:0] count_wide;
  logic [ID_W+15:0] front_wide;
  logic [ID_W-1:0]  new_id;

  fcspq_pkg::fcspq_ctrl_t ctrl;

  logic [ID_W-1:0] cell_id   [QUEUE_DEPTH];
  logic [1:0]      cell_cls  [QUEUE_DEPTH];
  logic            cell_keep [QUEUE_DEPTH];

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign is_full  = (count_r == DEPTH_C);
  assign is_empty = (count_r == '0);
  assign new_id   = in_patient_id[ID_W-1:0];

  assign ctrl.do_add  = in_fire && (in_cmd == fcspq_pkg::CMD_ADD) && !is_full;
  assign ctrl.do_call = in_fire && (in_cmd == fcspq_pkg::CMD_CALL) && !is_empty;
  assign ctrl.new_cls = in_urgency;

  genvar i;
  generate
    for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic            left_keep;
      logic [ID_W-1:0] left_id, right_id;
      logic [1:0]      left_cls, right_cls;
      if (i == 0) begin : g_head
        assign left_keep = 1'b1;
        assign left_id   = new_id;
        assign left_cls  = in_urgency;
      end else begin : g_mid
        assign left_keep = cell_keep[i-1];
        assign left_id   = cell_id[i-1];
        assign left_cls  = cell_cls[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin : g_tail
        assign right_id  = cell_id[i];
        assign right_cls = cell_cls[i];
      end else begin : g_body
        assign right_id  = cell_id[i+1];
        assign right_cls = cell_cls[i+1];
      end
      fcspq_cell #(.ID_W(ID_W)) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .new_id     (new_id),
        .slot_valid (count_r > CNT_W'(i)),
        .left_keep  (left_keep),
        .left_id    (left_id),
        .left_cls   (left_cls),
        .right_id   (right_id),
        .right_cls  (right_cls),
        .keep       (cell_keep[i]),
        .id         (cell_id[i]),
        .cls        (cell_cls[i])
      );
    end
  endgenerate

  assign front_wide = {16'b0, cell_id[0]};

  always_comb begin
    count_nxt = count_r;
    if (ctrl.do_add) begin
      count_nxt = count_r + 1'b1;
    end else if (ctrl.do_call) begin
      count_nxt = count_r - 1'b1;
    end
  end

  assign count_wide = {5'b0, count_nxt};

  always_comb begin
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    served_nxt    = served_r;
    room_nxt      = room_r;
    waiting_nxt   = waiting_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      out_valid_nxt = 1'b1;
      served_nxt    = '0;
      room_nxt      = '0;
      waiting_nxt   = count_wide[4:0];
      if (in_cmd == fcspq_pkg::CMD_ADD) begin
        status_nxt = is_full ? fcspq_pkg::ST_FULL : fcspq_pkg::ST_ADDED;
      end else if (is_empty) begin
        status_nxt = fcspq_pkg::ST_EMPTY;
      end else begin
        status_nxt = fcspq_pkg::ST_CALLED;
        served_nxt = front_wide[15:0];
        room_nxt   = fcspq_pkg::class_room(cell_cls[0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    status_r  <= status_nxt;
    served_r  <= served_nxt;
    room_r    <= room_nxt;
    waiting_r <= waiting_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_served_id = served_r;
  assign out_room      = room_r;
  assign out_waiting   = waiting_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("entry count above depth");

  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.do_add |=> count_r == $past(count_r) + 1'b1)
    else $error("accepted add did not grow the queue");

  a_empty_call_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_cmd == fcspq_pkg::CMD_CALL) && is_empty |=> is_empty)
    else $error("call on empty queue changed the count");

  a_noncall_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != fcspq_pkg::ST_CALLED) |->
      (out_served_id == 16'd0) && (out_room == 2'd0))
    else $error("served fields set on a non-call result");
`endif

endmodule

[dv/four_class_stable_priority_queue_tb.sv]
// Self-checking testbench for the four-class stable priority queue.
`timescale 1ns / 1ps

module four_class_stable_priority_queue_tb;

  localparam int QUEUE_DEPTH = 16;
  localparam int PHASE_ITEMS = 230;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] served_id;
    logic [1:0]  room;
    logic [4:0]  waiting;
  } triage_result_t;

  // Mirror of the sorted queue; each request yields the result it must produce.
  class triage_predictor;
    logic [15:0]    held_ids[QUEUE_DEPTH];
    logic [1:0]     held_classes[QUEUE_DEPTH];
    int             held_count;
    triage_result_t pending_results[$];
    int             mismatches;

    function new();
      held_count = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void log_request(logic cmd, logic [15:0] id, logic [1:0] urg);
      triage_result_t res;
      int             pos;
      res = '0;
      if (cmd == fcspq_pkg::CMD_ADD) begin
        if (held_count >= QUEUE_DEPTH) begin
          res.status = fcspq_pkg::ST_FULL;
        end else begin
          // new entry goes behind every entry of the same or a more urgent class
          pos = 0;
          while (pos < held_count && held_classes[pos] <= urg) pos++;
          for (int k = held_count; k > pos; k--) begin
            held_ids[k]     = held_ids[k - 1];
            held_classes[k] = held_classes[k - 1];
          end
          held_ids[pos]     = id;
          held_classes[pos] = urg;
          held_count++;
          res.status = fcspq_pkg::ST_ADDED;
        end
      end else if (held_count == 0) begin
        res.status = fcspq_pkg::ST_EMPTY;
      end else begin
        res.served_id = held_ids[0];
        res.room      = (held_classes[0] > 2'd1) ? fcspq_pkg::ROOM_TWO : held_classes[0];
        for (int k = 1; k < held_count; k++) begin
          held_ids[k - 1]     = held_ids[k];
          held_classes[k - 1] = held_classes[k];
        end
        held_count--;
        res.status = fcspq_pkg::ST_CALLED;
      end
      res.waiting = held_count[4:0];
      pending_results.push_back(res);
    endfunction

    function void check_result(logic [1:0] status, logic [15:0] served_id,
                               logic [1:0] room, logic [4:0] waiting);
      triage_result_t exp_res;
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d served_id %0h", status, served_id);
        mismatches++;
        return;
      end
      exp_res = pending_results.pop_front();
      if (status !== exp_res.status) begin
        $error("status: expected %0d, got %0d", exp_res.status, status);
        mismatches++;
      end
      if (served_id !== exp_res.served_id) begin
        $error("served_id: expected %0h, got %0h", exp_res.served_id, served_id);
        mismatches++;
      end
      if (room !== exp_res.room) begin
        $error("room: expected %0d, got %0d", exp_res.room, room);
        mismatches++;
      end
      if (waiting !== exp_res.waiting) begin
        $error("waiting: expected %0d, got %0d", exp_res.waiting, waiting);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_cmd;
  logic [15:0] in_patient_id;
  logic [1:0]  in_urgency;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [15:0] out_served_id;
  logic [1:0]  out_room;
  logic [4:0]  out_waiting;

  int              send_idle_pct = 0;
  int              recv_stall_pct = 0;
  triage_predictor triage = new();

  four_class_stable_priority_queue dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_patient_id(in_patient_id),
    .in_urgency   (in_urgency),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_served_id(out_served_id),
    .out_room     (out_room),
    .out_waiting  (out_waiting)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      triage.check_result(out_status, out_served_id, out_room, out_waiting);
    end
  end

  task automatic send_request(input logic cmd, input logic [15:0] id,
                              input logic [1:0] urg);
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_patient_id <= id;
    in_urgency    <= urg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    triage.log_request(cmd, id, urg);
  endtask

  task automatic drain_queue();
    @(negedge clk);
    in_valid <= 1'b0;
    while (triage.pending() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    logic [15:0] id;
    send_request(fcspq_pkg::CMD_CALL, 16'hFFFF, 2'd3);  // call while empty
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      id = (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : (16'hA5A5 ^ 16'(i * 16'h1111));
      send_request(fcspq_pkg::CMD_ADD, id, 2'(3 - (i % 4)));
    end
    send_request(fcspq_pkg::CMD_ADD, 16'h5A5A, 2'd0);  // full: dropped
    repeat (7) send_request(fcspq_pkg::CMD_CALL, 16'h0000, 2'd0);
  endtask

  // bursts with a changing add/call mix so the queue swings between empty and full
  task automatic run_random(input int n_items);
    int left;
    int burst;
    int add_pct;
    left = n_items;
    while (left > 0) begin
      burst = $urandom_range(16, 60);
      case ($urandom_range(2))
        0:       add_pct = 25;
        1:       add_pct = 50;
        default: add_pct = 80;
      endcase
      while (burst > 0 && left > 0) begin
        send_request(($urandom_range(99) < add_pct) ? fcspq_pkg::CMD_ADD
                                                    : fcspq_pkg::CMD_CALL,
                     16'($urandom_range(16'hFFFF)), 2'($urandom_range(3)));
        burst--;
        left--;
      end
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_cmd        <= fcspq_pkg::CMD_ADD;
    in_patient_id <= '0;
    in_urgency    <= '0;
    out_ready     <= 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    drain_queue();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      run_random(PHASE_ITEMS);
      drain_queue();
    end

    repeat (8) @(posedge clk);
    if (triage.mismatches == 0 && triage.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
